// ===== design/bjov_pkg.sv =====
// Package for the bounded JSON object validator.
// Holds the item structs, lexer state codes, byte constants and character-class helpers.
// Depends on nothing; every design file imports it.
`timescale 1ns / 1ps

package bjov_pkg;

  // Widths fixed by the item fields and the lexer counters.
  localparam int BYTES_W = 13;
  localparam int HEX_W   = 3;
  localparam int LIT_W   = 3;

  localparam logic [BYTES_W-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [HEX_W-1:0]   HEX_DIGITS  = 3'd4;

  // Container kinds kept on the stack.
  localparam logic KIND_OBJ = 1'b0;
  localparam logic KIND_ARR = 1'b1;

  // Bytes with a syntactic role.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_CTRL_END  = 8'h20;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_E     = 8'h65;
  localparam logic [7:0] CH_UP_E      = 8'h45;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_L     = 8'h6C;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_S     = 8'h73;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_LOW_A     = 8'h61;

  // One input item: a byte of the text and its end mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result item, given on the last byte of a text.
  typedef struct packed {
    logic               object_valid;
    logic [BYTES_W-1:0] byte_count;
  } out_item_t;

  // Stack commands from the lexer.
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
    logic clear;
  } stk_ctrl_t;

  // Lexer states, one-hot.
  typedef enum logic [24:0] {
    LX_PRE      = 25'h0000001,
    LX_OBJ_OPEN = 25'h0000002,
    LX_KEY_STR  = 25'h0000004,
    LX_KEY_ESC  = 25'h0000008,
    LX_KEY_HEX  = 25'h0000010,
    LX_COLON    = 25'h0000020,
    LX_VALUE    = 25'h0000040,
    LX_ARR_OPEN = 25'h0000080,
    LX_AFTER    = 25'h0000100,
    LX_NEXT_KEY = 25'h0000200,
    LX_VAL_STR  = 25'h0000400,
    LX_VAL_ESC  = 25'h0000800,
    LX_VAL_HEX  = 25'h0001000,
    LX_N_MINUS  = 25'h0002000,
    LX_N_ZERO   = 25'h0004000,
    LX_N_INT    = 25'h0008000,
    LX_N_DOT    = 25'h0010000,
    LX_N_FRAC   = 25'h0020000,
    LX_N_E      = 25'h0040000,
    LX_N_ESIGN  = 25'h0080000,
    LX_N_EXP    = 25'h0100000,
    LX_LIT_T    = 25'h0200000,
    LX_LIT_F    = 25'h0400000,
    LX_LIT_N    = 25'h0800000,
    LX_DONE     = 25'h1000000
  } lx_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Escapes that stand alone after a backslash.
  function automatic logic is_simple_escape(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_BACKSLASH) || (c == CH_SLASH) || (c == CH_LOW_B) ||
           (c == CH_LOW_F) || (c == CH_LOW_N) || (c == CH_LOW_R) || (c == CH_LOW_T);
  endfunction

  // Length of the literal word for a literal state.
  function automatic logic [LIT_W-1:0] lit_len(input lx_state_t st);
    return (st == LX_LIT_F) ? 3'd5 : 3'd4;
  endfunction

  // Expected byte at a position of the literal word.
  function automatic logic [7:0] lit_char(input lx_state_t st, input logic [LIT_W-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (st == LX_LIT_T) begin
      case (pos)
        3'd0:    ch = CH_LOW_T;
        3'd1:    ch = CH_LOW_R;
        3'd2:    ch = CH_LOW_U;
        3'd3:    ch = CH_LOW_E;
        default: ch = 8'h00;
      endcase
    end else if (st == LX_LIT_F) begin
      case (pos)
        3'd0:    ch = CH_LOW_F;
        3'd1:    ch = CH_LOW_A;
        3'd2:    ch = CH_LOW_L;
        3'd3:    ch = CH_LOW_S;
        3'd4:    ch = CH_LOW_E;
        default: ch = 8'h00;
      endcase
    end else begin
      case (pos)
        3'd0:    ch = CH_LOW_N;
        3'd1:    ch = CH_LOW_U;
        3'd2:    ch = CH_LOW_L;
        3'd3:    ch = CH_LOW_L;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== design/bjov_stack.sv =====
// Container stack of the validator: one kind bit per open object or array.
// Uses bjov_pkg for the command struct and kind codes.
`timescale 1ns / 1ps

module bjov_stack
  import bjov_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stk_ctrl_t                         ctrl,
  output logic [$clog2(MAX_DEPTH+2)-1:0]    depth,
  output logic                              top
);

  localparam int ENTRIES = MAX_DEPTH + 1;
  localparam int IDX_W   = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W   = $clog2(MAX_DEPTH + 2);

  logic [ENTRIES-1:0] kinds;
  logic [IDX_W-1:0]   top_idx;

  // Kind of the innermost open container; an empty stack reads as an object.
  assign top_idx = IDX_W'(depth - CNT_W'(1));
  assign top     = (depth == '0) ? KIND_OBJ : kinds[top_idx];

  // Depth counter; a clear at the end of a text wins over any command.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctrl.clear) begin
      depth <= '0;
    end else if (ctrl.push) begin
      depth <= depth + CNT_W'(1);
    end else if (ctrl.pop) begin
      depth <= depth - CNT_W'(1);
    end
  end

  // Kind bits are only read below the depth, so they need no reset.
  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      kinds[depth[IDX_W-1:0]] <= ctrl.kind;
    end
  end

endmodule

// ===== design/bjov_lexer.sv =====
// Byte lexer of the validator: state machine, string and literal counters,
// byte counter and error flag; one byte per step. Uses bjov_pkg and bjov_stack.
`timescale 1ns / 1ps

module bjov_lexer
  import bjov_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  in_item_t           item,
  input  logic [BYTES_W-1:0] limit,
  output out_item_t          result
);

  localparam int CNT_W = $clog2(MAX_DEPTH + 2);
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(MAX_DEPTH);

  lx_state_t          state;
  lx_state_t          state_next;
  logic               error_seen;
  logic               error_next;
  logic [HEX_W-1:0]   hex_left;
  logic [HEX_W-1:0]   hex_next;
  logic [LIT_W-1:0]   lit_pos;
  logic [LIT_W-1:0]   lit_next;
  logic [BYTES_W-1:0] bytes_seen;
  logic [BYTES_W-1:0] bytes_next;

  logic [CNT_W-1:0]   depth;
  logic               top;
  stk_ctrl_t          stk;

  logic [7:0]         c;
  logic               do_after;
  logic               do_value;
  logic               push_req;
  logic               push_kind;
  lx_state_t          push_state;
  logic               pop_req;
  logic               pop_kind;
  logic               push_ok;
  logic               pop_ok;

  bjov_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (stk),
    .depth (depth),
    .top   (top)
  );

  assign c = item.data_byte;

  // Next-state logic for one byte.
  always_comb begin
    state_next = state;
    error_next = error_seen;
    hex_next   = hex_left;
    lit_next   = lit_pos;
    bytes_next = bytes_seen;
    do_after   = 1'b0;
    do_value   = 1'b0;
    push_req   = 1'b0;
    push_kind  = KIND_OBJ;
    push_state = LX_OBJ_OPEN;
    pop_req    = 1'b0;
    pop_kind   = KIND_OBJ;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;

    // Length check comes first; the count stops at the limit.
    if (bytes_seen >= limit) begin
      error_next = 1'b1;
    end else begin
      bytes_next = bytes_seen + BYTES_W'(1);
    end

    if (!error_next) begin
      unique case (state) inside
        LX_PRE: begin
          if (c == CH_LBRACE) begin
            push_req   = 1'b1;
            push_kind  = KIND_OBJ;
            push_state = LX_OBJ_OPEN;
          end else if (!is_ws(c)) begin
            error_next = 1'b1;
          end
        end
        LX_OBJ_OPEN: begin
          if (c == CH_QUOTE) begin
            state_next = LX_KEY_STR;
          end else if (c == CH_RBRACE) begin
            pop_req  = 1'b1;
            pop_kind = KIND_OBJ;
          end else if (!is_ws(c)) begin
            error_next = 1'b1;
          end
        end
        LX_NEXT_KEY: begin
          if (c == CH_QUOTE) begin
            state_next = LX_KEY_STR;
          end else if (!is_ws(c)) begin
            error_next = 1'b1;
          end
        end
        LX_KEY_STR, LX_VAL_STR: begin
          if (c == CH_QUOTE) begin
            state_next = (state == LX_KEY_STR) ? LX_COLON : LX_AFTER;
          end else if (c < CH_CTRL_END) begin
            error_next = 1'b1;
          end else if (c == CH_BACKSLASH) begin
            state_next = (state == LX_KEY_STR) ? LX_KEY_ESC : LX_VAL_ESC;
          end
        end
        LX_KEY_ESC, LX_VAL_ESC: begin
          if (is_simple_escape(c)) begin
            state_next = (state == LX_KEY_ESC) ? LX_KEY_STR : LX_VAL_STR;
          end else if (c == CH_LOW_U) begin
            hex_next   = HEX_DIGITS;
            state_next = (state == LX_KEY_ESC) ? LX_KEY_HEX : LX_VAL_HEX;
          end else begin
            error_next = 1'b1;
          end
        end
        LX_KEY_HEX, LX_VAL_HEX: begin
          if (!is_hex(c) || (hex_left == '0)) begin
            error_next = 1'b1;
          end else begin
            hex_next = hex_left - HEX_W'(1);
            if (hex_left == HEX_W'(1)) begin
              state_next = (state == LX_KEY_HEX) ? LX_KEY_STR : LX_VAL_STR;
            end
          end
        end
        LX_COLON: begin
          if (c == CH_COLON) begin
            state_next = LX_VALUE;
          end else if (!is_ws(c)) begin
            error_next = 1'b1;
          end
        end
        LX_VALUE: begin
          if (!is_ws(c)) begin
            do_value = 1'b1;
          end
        end
        LX_ARR_OPEN: begin
          if (c == CH_RBRACKET) begin
            pop_req  = 1'b1;
            pop_kind = KIND_ARR;
          end else if (!is_ws(c)) begin
            do_value = 1'b1;
          end
        end
        LX_AFTER: begin
          do_after = 1'b1;
        end
        LX_N_MINUS: begin
          if (c == CH_ZERO) begin
            state_next = LX_N_ZERO;
          end else if (is_digit(c)) begin
            state_next = LX_N_INT;
          end else begin
            error_next = 1'b1;
          end
        end
        LX_N_ZERO, LX_N_INT: begin
          if (is_digit(c)) begin
            // A leading zero may not be followed by more digits.
            if (state == LX_N_ZERO) begin
              error_next = 1'b1;
            end
          end else if (c == CH_DOT) begin
            state_next = LX_N_DOT;
          end else if ((c == CH_LOW_E) || (c == CH_UP_E)) begin
            state_next = LX_N_E;
          end else begin
            do_after = 1'b1;
          end
        end
        LX_N_DOT: begin
          if (is_digit(c)) begin
            state_next = LX_N_FRAC;
          end else begin
            error_next = 1'b1;
          end
        end
        LX_N_FRAC: begin
          if (is_digit(c)) begin
            state_next = LX_N_FRAC;
          end else if ((c == CH_LOW_E) || (c == CH_UP_E)) begin
            state_next = LX_N_E;
          end else begin
            do_after = 1'b1;
          end
        end
        LX_N_E: begin
          if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            state_next = LX_N_ESIGN;
          end else if (is_digit(c)) begin
            state_next = LX_N_EXP;
          end else begin
            error_next = 1'b1;
          end
        end
        LX_N_ESIGN: begin
          if (is_digit(c)) begin
            state_next = LX_N_EXP;
          end else begin
            error_next = 1'b1;
          end
        end
        LX_N_EXP: begin
          if (!is_digit(c)) begin
            do_after = 1'b1;
          end
        end
        LX_LIT_T, LX_LIT_F, LX_LIT_N: begin
          if ((lit_pos >= lit_len(state)) || (lit_char(state, lit_pos) != c)) begin
            error_next = 1'b1;
          end else if (lit_pos + LIT_W'(1) == lit_len(state)) begin
            lit_next   = '0;
            state_next = LX_AFTER;
          end else begin
            lit_next = lit_pos + LIT_W'(1);
          end
        end
        LX_DONE: begin
          if (!is_ws(c)) begin
            error_next = 1'b1;
          end
        end
        default: begin
          error_next = 1'b1;
        end
      endcase

      // Byte after a value; a byte that ends a number is taken here again.
      if (do_after) begin
        state_next = LX_AFTER;
        if (c == CH_RBRACE) begin
          pop_req  = 1'b1;
          pop_kind = KIND_OBJ;
        end else if (c == CH_RBRACKET) begin
          pop_req  = 1'b1;
          pop_kind = KIND_ARR;
        end else if (c == CH_COMMA) begin
          if (depth == '0) begin
            error_next = 1'b1;
          end else begin
            state_next = (top == KIND_OBJ) ? LX_NEXT_KEY : LX_VALUE;
          end
        end else if (!is_ws(c)) begin
          error_next = 1'b1;
        end
      end

      // First byte of a value, with the depth bound.
      if (do_value) begin
        if (depth > DEPTH_MAX) begin
          error_next = 1'b1;
        end else if (c == CH_QUOTE) begin
          state_next = LX_VAL_STR;
        end else if (c == CH_LBRACE) begin
          push_req   = 1'b1;
          push_kind  = KIND_OBJ;
          push_state = LX_OBJ_OPEN;
        end else if (c == CH_LBRACKET) begin
          push_req   = 1'b1;
          push_kind  = KIND_ARR;
          push_state = LX_ARR_OPEN;
        end else if (c == CH_LOW_T) begin
          state_next = LX_LIT_T;
          lit_next   = LIT_W'(1);
        end else if (c == CH_LOW_F) begin
          state_next = LX_LIT_F;
          lit_next   = LIT_W'(1);
        end else if (c == CH_LOW_N) begin
          state_next = LX_LIT_N;
          lit_next   = LIT_W'(1);
        end else if (c == CH_MINUS) begin
          state_next = LX_N_MINUS;
        end else if (c == CH_ZERO) begin
          state_next = LX_N_ZERO;
        end else if (is_digit(c)) begin
          state_next = LX_N_INT;
        end else begin
          error_next = 1'b1;
        end
      end

      // Open a container unless the stack is full.
      if (push_req) begin
        if (depth > DEPTH_MAX) begin
          error_next = 1'b1;
        end else begin
          push_ok    = 1'b1;
          state_next = push_state;
        end
      end

      // Close a container; the kind must match the innermost one.
      if (pop_req) begin
        if ((depth == '0) || (top != pop_kind)) begin
          error_next = 1'b1;
        end else begin
          pop_ok     = 1'b1;
          state_next = (depth == CNT_W'(1)) ? LX_DONE : LX_AFTER;
        end
      end
    end
  end

  // Stack commands; the end of a text empties the stack.
  always_comb begin
    stk.push  = step && !item.last_byte && push_ok;
    stk.pop   = step && !item.last_byte && pop_ok;
    stk.kind  = push_kind;
    stk.clear = step && item.last_byte;
  end

  // Result of the text, valid on a step with the last byte.
  always_comb begin
    result.object_valid = !error_next && (state_next == LX_DONE);
    result.byte_count   = bytes_next;
  end

  // Lexer registers; all return to their start values after a last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LX_PRE;
      error_seen <= 1'b0;
      hex_left   <= '0;
      lit_pos    <= '0;
      bytes_seen <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        state      <= LX_PRE;
        error_seen <= 1'b0;
        hex_left   <= '0;
        lit_pos    <= '0;
        bytes_seen <= '0;
      end else begin
        state      <= state_next;
        error_seen <= error_next;
        hex_left   <= hex_next;
        lit_pos    <= lit_next;
        bytes_seen <= bytes_next;
      end
    end
  end

endmodule

// ===== design/bounded_json_object_validator_unit.sv =====
// Top level of the bounded JSON object validator: input register, lexer,
// result register and the byte-limit register. Uses bjov_pkg and bjov_lexer.
`timescale 1ns / 1ps

// Usage:
// The in channel takes one byte of a JSON text per item (in_valid, in_stall,
// in_data); last_byte marks the final byte of a text. For each text the out
// channel (out_valid, out_stall, out_data) gives one item: object_valid is set
// when the text was exactly one well-formed object, with optional whitespace
// around it, within the nesting bound and the byte limit; byte_count is the
// number of bytes seen, saturating at the limit.
// cfg_write with cfg_data sets the byte limit (reset value 4096); write it only
// while no text is in progress and no result is pending.
// Throughput: one byte per cycle while no held result stalls a last byte, set by
// the lexer step between the input register and the result register. A result is
// shown once its last byte has passed the input register and stepped the lexer
// into the result register.
// Reset clears the lexer, the stack and both registers at once; the block can take
// items right after reset.
// When out_stall holds a result, bytes that are not the last of a text keep
// flowing; a last byte waits in the input register, and in_stall is raised,
// until the result register frees up.

module bounded_json_object_validator_unit
  import bjov_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_write,
  input  logic [BYTES_W-1:0] cfg_data
);

  logic               in_reg_valid;
  in_item_t           in_reg;
  logic               out_free;
  logic               step;
  logic [BYTES_W-1:0] max_object_bytes;
  out_item_t          result;

  // A byte steps the lexer unless it ends a text and the result register is full.
  assign out_free = !out_valid || !out_stall;
  assign step     = in_reg_valid && (!in_reg.last_byte || out_free);
  assign in_stall = in_reg_valid && !step;

  // Byte limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_object_bytes <= LIMIT_RESET;
    end else if (cfg_write) begin
      max_object_bytes <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg <= in_data;
    end
  end

  bjov_lexer #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_lexer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_reg),
    .limit  (max_object_bytes),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_reg.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_reg.last_byte) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // A new result appears only after a last byte went through the lexer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && in_reg.last_byte))
    else $error("result shown without a last byte");

  // The input side waits only behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_reg.last_byte))
    else $error("input stalled without a held result");

  // A valid object always has at least one counted byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.object_valid) |-> (out_data.byte_count != '0))
    else $error("valid object with zero byte count");
`endif

endmodule
